// ----- hdl/scfd_pkg.sv -----
// ---------------------------------------------------------------------------
// scfd_pkg
// Shared constants and types of the serial CAN frame deframer.
// ---------------------------------------------------------------------------
package scfd_pkg;

   // payload store capacity: default and upper bound of the range
   localparam int MAX_PAYLOAD_DEF = 64;
   localparam int MAX_PAYLOAD_TOP = 64;
   // wide enough for a payload count of 0..MAX_PAYLOAD_TOP
   localparam int CNT_W = $clog2(MAX_PAYLOAD_TOP + 1);
   localparam int QUEUE_DEPTH = 4;

   // serial byte codes
   localparam logic [7:0] ESC_BYTE    = 8'h7f;
   localparam logic [7:0] TYPE_STD    = 8'h80;
   localparam logic [7:0] TYPE_EXT    = 8'h81;
   localparam logic [7:0] ST_INIT_OK  = 8'h00;
   localparam logic [7:0] ST_INIT_ERR = 8'hff;
   localparam logic [7:0] ST_SEND_OK  = 8'h01;
   localparam logic [7:0] ST_SEND_ERR = 8'hfe;
   localparam logic [7:0] ST_WATCHDOG = 8'h02;

   // header lengths including type and length bytes
   localparam logic [8:0] HDR_STD   = 9'd4;
   localparam logic [8:0] HDR_EXT   = 9'd6;
   localparam logic [8:0] COUNT_MAX = 9'd511;

   // result kinds
   localparam logic [2:0] KIND_INIT_OK  = 3'd0;
   localparam logic [2:0] KIND_INIT_ERR = 3'd1;
   localparam logic [2:0] KIND_SEND_OK  = 3'd2;
   localparam logic [2:0] KIND_SEND_ERR = 3'd3;
   localparam logic [2:0] KIND_WATCHDOG = 3'd4;
   localparam logic [2:0] KIND_STD      = 3'd5;
   localparam logic [2:0] KIND_EXT      = 3'd6;

   // one finished frame or status event, handed from parser to drain
   typedef struct packed {
      logic [2:0]       kind;
      logic [31:0]      frame_id;
      logic [7:0]       frame_length;
      logic [CNT_W-1:0] count;
      logic             truncated;
      logic             bank;
   } job_type;

   // payload store write from the parser
   typedef struct packed {
      logic             valid;
      logic             bank;
      logic [CNT_W-2:0] index;
      logic [7:0]       data;
   } wr_type;

   // bank handed back by the drain after its last read
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

endpackage

// ----- hdl/scfd_req_if.sv -----
// ---------------------------------------------------------------------------
// scfd_req_if
// Byte channel into the deframer: valid/ready with one raw serial byte.
// ---------------------------------------------------------------------------
interface scfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/scfd_rsp_if.sv -----
// ---------------------------------------------------------------------------
// scfd_rsp_if
// Result channel out of the deframer: valid/ready with one result beat.
// ---------------------------------------------------------------------------
interface scfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] frame_id;
   logic [7:0]  frame_length;
   logic [7:0]  data_byte;
   logic        has_byte;
   logic        truncated;
   logic        last;

   modport source (output valid, output kind, output frame_id, output frame_length,
                   output data_byte, output has_byte, output truncated, output last,
                   input ready);
   modport sink   (input valid, input kind, input frame_id, input frame_length,
                   input data_byte, input has_byte, input truncated, input last,
                   output ready);
endinterface

// ----- hdl/scfd_queue.sv -----
// ---------------------------------------------------------------------------
// scfd_queue
// Small register FIFO of finished jobs between parser and drain.
// ---------------------------------------------------------------------------
module scfd_queue
   import scfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == DEPTH_CNT);
   assign head_job = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- hdl/scfd_parse.sv -----
// ---------------------------------------------------------------------------
// scfd_parse
// Front end: unescapes the byte stream, tracks frame position, collects
// header fields, writes payload bytes and queues finished frames/events.
// ---------------------------------------------------------------------------
module scfd_parse
   import scfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
   input  logic        clock,
   input  logic        reset,
   scfd_req_if.sink    req_chan,
   input  logic        q_full,
   input  release_type rel,
   output logic        q_push,
   output job_type     q_job,
   output wr_type      wr
);

   localparam logic [8:0]       MAX_P9 = 9'(MAX_PAYLOAD);
   localparam logic [7:0]       MAX_P8 = 8'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0] MAX_N  = CNT_W'(MAX_PAYLOAD);

   logic        esc_ff, esc_in;
   logic [8:0]  count_ff, count_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  len_ff, len_in;
   logic [31:0] id_ff, id_in;
   logic        bank_ff, bank_in;
   logic [1:0]  busy_ff, busy_in;

   logic        accept;
   logic [7:0]  b;
   logic [8:0]  pos;
   logic [8:0]  hdr;
   logic [8:0]  pos_next;
   logic [8:0]  pay_idx;
   logic        trunc;
   logic [CNT_W-1:0] n_bytes;

   assign req_chan.ready = !q_full && !busy_ff[bank_ff];
   assign accept = req_chan.valid && req_chan.ready;
   assign b      = req_chan.rx_byte;

   always_comb begin
      esc_in   = esc_ff;
      count_in = count_ff;
      type_in  = type_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      q_push   = 1'b0;
      q_job    = '0;
      wr       = '0;
      wr.bank  = bank_ff;
      wr.data  = b;
      pos      = ((b != ESC_BYTE) && esc_ff) ? 9'd0 : count_ff;
      hdr      = (type_ff == TYPE_STD) ? HDR_STD : HDR_EXT;
      pos_next = pos + 9'd1;
      pay_idx  = pos - hdr;
      wr.index = pay_idx[CNT_W-2:0];
      trunc    = (len_ff > MAX_P8);
      n_bytes  = trunc ? MAX_N : len_ff[CNT_W-1:0];

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end

      if (accept) begin
         if ((b == ESC_BYTE) && !esc_ff) begin
            esc_in = 1'b1;
         end else begin
            esc_in = 1'b0;
            if (pos == 9'd0) begin
               type_in  = b;
               len_in   = 8'd0;
               id_in    = 32'd0;
               count_in = 9'd0;
               q_job    = '0;
               case (b)
                  ST_INIT_OK: begin
                     q_push = 1'b1;
                     q_job.kind = KIND_INIT_OK;
                  end
                  ST_INIT_ERR: begin
                     q_push = 1'b1;
                     q_job.kind = KIND_INIT_ERR;
                  end
                  ST_SEND_OK: begin
                     q_push = 1'b1;
                     q_job.kind = KIND_SEND_OK;
                  end
                  ST_SEND_ERR: begin
                     q_push = 1'b1;
                     q_job.kind = KIND_SEND_ERR;
                  end
                  ST_WATCHDOG: begin
                     q_push = 1'b1;
                     q_job.kind = KIND_WATCHDOG;
                  end
                  default: begin
                     count_in = 9'd1;
                  end
               endcase
            end else if ((type_ff == TYPE_STD) || (type_ff == TYPE_EXT)) begin
               count_in = pos_next;
               if (pos == 9'd1) begin
                  len_in = b;
               end else if (pos < hdr) begin
                  id_in = {id_ff[23:0], b};
               end else if (pay_idx < MAX_P9) begin
                  wr.valid = 1'b1;
               end
               // length byte sits at position one, so len_ff is current here
               if ((pos_next >= hdr) && (pos_next >= hdr + {1'b0, len_ff})) begin
                  q_push             = 1'b1;
                  q_job.kind         = (type_ff == TYPE_STD) ? KIND_STD : KIND_EXT;
                  // an empty frame ends on its last id byte
                  q_job.frame_id     = id_in;
                  q_job.frame_length = len_ff;
                  q_job.count        = n_bytes;
                  q_job.truncated    = trunc;
                  q_job.bank         = bank_ff;
                  count_in           = 9'd0;
                  if (n_bytes != '0) begin
                     busy_in[bank_ff] = 1'b1;
                     bank_in          = !bank_ff;
                  end
               end
            end else begin
               count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 9'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff   <= 1'b0;
         count_ff <= 9'd0;
         type_ff  <= 8'd0;
         len_ff   <= 8'd0;
         id_ff    <= 32'd0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
      end else begin
         esc_ff   <= esc_in;
         count_ff <= count_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      wr.valid |-> !busy_ff[wr.bank])
      else $error("payload write into a bank still being drained");

   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      rel.valid |-> busy_ff[rel.bank])
      else $error("release of a bank that was not busy");

endmodule

// ----- hdl/scfd_drain.sv -----
// ---------------------------------------------------------------------------
// scfd_drain
// Back end: holds the two-bank payload store and turns queued jobs into
// result beats, one stored byte per beat.
// ---------------------------------------------------------------------------
module scfd_drain
   import scfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  wr_type      wr,
   input  logic        q_empty,
   input  job_type     q_head,
   output logic        q_pop,
   output release_type rel,
   scfd_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = $clog2(2 * MAX_PAYLOAD);
   localparam logic [ADDR_W-1:0] BANK_OFS = ADDR_W'(MAX_PAYLOAD);

   logic [7:0] mem [2 * MAX_PAYLOAD];
   logic [7:0] mem_q_ff;

   logic             active_ff, active_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  kind_ff;
   logic [31:0] id_ff;
   logic [7:0]  len_ff;
   logic        has_ff;
   logic        trunc_ff;
   logic        last_ff;

   job_type          cur;
   logic [CNT_W-1:0] cur_idx;
   logic             advance, issue, final_beat, rd_en;
   logic [ADDR_W-1:0] waddr, raddr;

   assign waddr = wr.bank ? BANK_OFS + ADDR_W'(wr.index) : ADDR_W'(wr.index);

   always_comb begin
      cur        = active_ff ? job_ff : q_head;
      cur_idx    = active_ff ? idx_ff : '0;
      advance    = !rsp_valid_ff || rsp_chan.ready;
      issue      = advance && (active_ff || !q_empty);
      final_beat = (cur.count == '0) || (cur_idx + 1'b1 == cur.count);
      rd_en      = issue && (cur.count != '0);
      raddr      = cur.bank ? BANK_OFS + ADDR_W'(cur_idx) : ADDR_W'(cur_idx);
      q_pop      = issue && !active_ff;
      rel.valid  = issue && final_beat && (cur.count != '0);
      rel.bank   = cur.bank;

      active_in    = active_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      rsp_valid_in = advance ? issue : rsp_valid_ff;
      if (issue) begin
         active_in = !final_beat;
         job_in    = cur;
         idx_in    = cur_idx + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.valid) begin
         mem[waddr] <= wr.data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      if (issue) begin
         kind_ff  <= cur.kind;
         id_ff    <= cur.frame_id;
         len_ff   <= cur.frame_length;
         has_ff   <= (cur.count != '0);
         trunc_ff <= cur.truncated;
         last_ff  <= final_beat;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = kind_ff;
   assign rsp_chan.frame_id     = id_ff;
   assign rsp_chan.frame_length = len_ff;
   assign rsp_chan.data_byte    = has_ff ? mem_q_ff : 8'd0;
   assign rsp_chan.has_byte     = has_ff;
   assign rsp_chan.truncated    = trunc_ff;
   assign rsp_chan.last         = last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff < job_ff.count))
      else $error("drain index ran past the job's byte count");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff != KIND_STD) && (kind_ff != KIND_EXT))
         |-> (!has_ff && last_ff && (id_ff == 32'd0)))
      else $error("status event beat carries frame data");

   a_no_pop_midjob: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !q_pop)
      else $error("queue popped while a frame is still draining");

endmodule

// ----- hdl/serial_can_frame_deframer.sv -----
// ---------------------------------------------------------------------------
// serial_can_frame_deframer
// Rebuilds CAN frames and status events from an escaped serial byte stream.
// ---------------------------------------------------------------------------
// req_chan carries one received byte per beat; rsp_chan carries results.
// 0x7f starts a frame, 0x7f 0x7f is a literal 0x7f. Status frames give one
// beat; standard (0x80) and extended (0x81) frames give one beat per stored
// payload byte, or one beat for an empty payload, with last on the final one.
// The first result of a completed frame or event passes through the job
// queue and then the output register before it is valid on rsp_chan.
// Throughput: the parser takes one byte per cycle while req_chan.ready is
// high; the drain sends one beat per cycle while rsp_chan is not stalled.
// Payload goes into one of two banks; while the drain still reads the bank
// the parser wants next, or the four-entry job queue is full, ready stays
// low, so a frame can hold the input only once the next finishes behind it.
// Reset (synchronous) clears the parser state, the queue and the output
// register; the payload store needs no clearing.
// A stall on rsp_chan holds the output beat; the queue and the second bank
// keep taking bytes until they fill, then ready drops.
// ---------------------------------------------------------------------------
module serial_can_frame_deframer
   import scfd_pkg::*;
#(
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
   input  logic       clock,
   input  logic       reset,
   scfd_req_if.sink   req_chan,
   scfd_rsp_if.source rsp_chan
);

   logic        q_push, q_pop, q_empty, q_full;
   job_type     q_job, q_head;
   wr_type      wr;
   release_type rel;

   scfd_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .rel      (rel),
      .q_push   (q_push),
      .q_job    (q_job),
      .wr       (wr)
   );

   scfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   scfd_drain #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_drain (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rel      (rel),
      .rsp_chan (rsp_chan)
   );

endmodule
